/* hw/rtl/tdh_pkg.sv */
// Shared types, constants and helpers for the twilight dark hysteresis block.
package tdh_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned LvlW  = 16;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;
  localparam logic [CntW-1:0] CntMax = '1;

  // Register indexes on the configuration port.
  typedef enum logic [IdxW-1:0] {
    REG_ENTER_AMB  = 3'd0,
    REG_ENTER_FWD  = 3'd1,
    REG_ENTER_TIME = 3'd2,
    REG_LEAVE_AMB  = 3'd3,
    REG_LEAVE_FWD  = 3'd4,
    REG_LEAVE_TIME = 3'd5,
    REG_IR_NIGHT   = 3'd6
  } reg_idx_e;

  // Item kinds carried in tuser.
  localparam logic KindTick = 1'b0;
  localparam logic KindInit = 1'b1;

  // Reset values of the registers and of the values derived from them.
  localparam logic [LvlW-1:0] RstEnterAmb  = 16'd1000;
  localparam logic [LvlW-1:0] RstEnterAmb3 = 16'd333;
  localparam logic [LvlW-1:0] RstEnterFwd  = 16'd1000;
  localparam logic [LvlW:0]   RstEnterFwd15 = 17'd1500;
  localparam logic [CntW-1:0] RstEnterTime = 16'd60;
  localparam logic [LvlW-1:0] RstLeaveAmb  = 16'd1500;
  localparam logic [LvlW-1:0] RstLeaveFwd  = 16'd1500;
  localparam logic [CntW-1:0] RstLeaveTime = 16'd60;
  localparam logic [LvlW-1:0] RstIrNight3  = 16'd85;

  // Thresholds as the decision logic sees them.
  typedef struct packed {
    logic [LvlW-1:0] enter_amb;
    logic [LvlW-1:0] enter_amb3;
    logic [LvlW-1:0] enter_fwd;
    logic [LvlW:0]   enter_fwd15;
    logic [CntW-1:0] enter_time;
    logic [LvlW-1:0] leave_amb;
    logic [LvlW-1:0] leave_fwd;
    logic [CntW-1:0] leave_time;
    logic [LvlW-1:0] ir_night3;
  } tdh_cfg_t;

  // Exact truncating divide by three of a 16-bit value by reciprocal multiply.
  function automatic logic [LvlW-1:0] div3(input logic [LvlW-1:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd43691;
    return {1'b0, prod[31:17]};
  endfunction

endpackage

/* hw/rtl/twilight_dark_hysteresis.sv */
// Top level of the twilight dark hysteresis block.
// Usage:
//   Light samples arrive as beats on the s_axis channel; tuser carries the kind
//   (tick or initialization), tdata the twilight flag and the three samples.
//   Every input beat yields exactly one result beat on m_axis with the dark
//   flag and both qualification counters as they stand after that beat.
//   Thresholds and qualification times are written through the cfg port,
//   one register per cycle, while no beat is in flight.
// Pipeline and throughput:
//   A beat is registered on entry and its result is registered on exit: the
//   entry register feeds the decision, whose mode and counters are written to
//   the result register. The mode and counters update from the entry register,
//   so one beat per cycle is sustained while m_axis_tready stays high.
// Reset:
//   Reset clears both stages, sets the mode to not dark, clears both counters
//   and loads the default thresholds.
// Stalls:
//   When m_axis_tready is low the result holds; the entry register still takes
//   one more beat, after which s_axis_tready drops until the result drains.
module twilight_dark_hysteresis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] twilight_on, [16:1] ambient_level, [32:17] forward_level,
  // [48:33] infrared_level, [55:49] zero
  input  logic [tdh_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] dark_active, [16:1] enter_count, [32:17] leave_count, [39:33] zero
  output logic [tdh_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [tdh_pkg::IdxW-1:0]      cfg_idx_i,
  input  logic [tdh_pkg::LvlW-1:0]      cfg_wdata_i
);

  tdh_pkg::tdh_cfg_t        cfg;
  logic                     dark;
  logic [tdh_pkg::CntW-1:0] enter_cnt, leave_cnt;

  tdh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tdh_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (s_axis_tuser),
    .in_twilight_i (s_axis_tdata[0]),
    .in_amb_i      (s_axis_tdata[16:1]),
    .in_fwd_i      (s_axis_tdata[32:17]),
    .in_ir_i       (s_axis_tdata[48:33]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_dark_o    (dark),
    .out_enter_o   (enter_cnt),
    .out_leave_o   (leave_cnt)
  );

  // Pack the result beat, zero padded to whole bytes.
  assign m_axis_tdata = {7'b0, leave_cnt, enter_cnt, dark};

endmodule

/* hw/rtl/tdh_cfg.sv */
// Configuration registers with the divided thresholds precomputed at write time.
module tdh_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tdh_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [tdh_pkg::LvlW-1:0]  cfg_wdata_i,
  output tdh_pkg::tdh_cfg_t         cfg_o
);

  tdh_pkg::tdh_cfg_t cfg_q, cfg_d;

  // Decode one register write; the derived thresholds follow their source.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdh_pkg::REG_ENTER_AMB: begin
          cfg_d.enter_amb  = cfg_wdata_i;
          cfg_d.enter_amb3 = tdh_pkg::div3(cfg_wdata_i);
        end
        tdh_pkg::REG_ENTER_FWD: begin
          cfg_d.enter_fwd   = cfg_wdata_i;
          cfg_d.enter_fwd15 = {1'b0, cfg_wdata_i} + {2'b0, cfg_wdata_i[tdh_pkg::LvlW-1:1]};
        end
        tdh_pkg::REG_ENTER_TIME: cfg_d.enter_time = cfg_wdata_i;
        tdh_pkg::REG_LEAVE_AMB:  cfg_d.leave_amb  = cfg_wdata_i;
        tdh_pkg::REG_LEAVE_FWD:  cfg_d.leave_fwd  = cfg_wdata_i;
        tdh_pkg::REG_LEAVE_TIME: cfg_d.leave_time = cfg_wdata_i;
        tdh_pkg::REG_IR_NIGHT:   cfg_d.ir_night3  = tdh_pkg::div3(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_amb   <= tdh_pkg::RstEnterAmb;
      cfg_q.enter_amb3  <= tdh_pkg::RstEnterAmb3;
      cfg_q.enter_fwd   <= tdh_pkg::RstEnterFwd;
      cfg_q.enter_fwd15 <= tdh_pkg::RstEnterFwd15;
      cfg_q.enter_time  <= tdh_pkg::RstEnterTime;
      cfg_q.leave_amb   <= tdh_pkg::RstLeaveAmb;
      cfg_q.leave_fwd   <= tdh_pkg::RstLeaveFwd;
      cfg_q.leave_time  <= tdh_pkg::RstLeaveTime;
      cfg_q.ir_night3   <= tdh_pkg::RstIrNight3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/tdh_core.sv */
// Input register, hysteresis decision, mode and counter state, result register.
module tdh_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdh_pkg::tdh_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_kind_i,
  input  logic                          in_twilight_i,
  input  logic [tdh_pkg::LvlW-1:0]      in_amb_i,
  input  logic [tdh_pkg::LvlW-1:0]      in_fwd_i,
  input  logic [tdh_pkg::LvlW-1:0]      in_ir_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_dark_o,
  output logic [tdh_pkg::CntW-1:0]      out_enter_o,
  output logic [tdh_pkg::CntW-1:0]      out_leave_o
);

  logic                     in_valid_q;
  logic                     kind_q, twl_q;
  logic [tdh_pkg::LvlW-1:0] amb_q, fwd_q, ir_q;
  logic                     out_valid_q;
  logic                     dark_q, dark_d;
  logic [tdh_pkg::CntW-1:0] enter_q, enter_d, leave_q, leave_d;
  logic                     out_free, advance;
  logic                     strong_hit, weak_hit, bright;
  logic [tdh_pkg::CntW:0]   enter_sum, leave_sum;

  // Handshake: a beat moves forward when the result slot is free or drains.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= in_kind_i;
      twl_q  <= in_twilight_i;
      amb_q  <= in_amb_i;
      fwd_q  <= in_fwd_i;
      ir_q   <= in_ir_i;
    end
  end

  // Darkness and brightness rules.
  assign strong_hit = (amb_q < cfg_i.enter_amb) && (fwd_q < cfg_i.enter_fwd);
  assign weak_hit   = (amb_q < cfg_i.enter_amb3) && ({1'b0, fwd_q} < cfg_i.enter_fwd15) &&
                      (ir_q < cfg_i.enter_amb3);
  assign bright     = (fwd_q > cfg_i.leave_fwd) && (amb_q > cfg_i.leave_amb) &&
                      (ir_q > cfg_i.ir_night3);

  assign enter_sum = {1'b0, enter_q} + (strong_hit ? 17'd3 : 17'd2);
  assign leave_sum = {1'b0, leave_q} + 17'd1;

  // Next mode and counters; an init beat sets the mode, else only the branch of the current mode runs.
  always_comb begin
    dark_d  = dark_q;
    enter_d = enter_q;
    leave_d = leave_q;
    if (kind_q == tdh_pkg::KindInit) begin
      dark_d = twl_q && strong_hit;
      if (dark_d) begin
        enter_d = '0;
      end else begin
        leave_d = '0;
      end
    end else if (!dark_q) begin
      if (strong_hit || weak_hit) begin
        if (enter_q >= cfg_i.enter_time) begin
          dark_d  = 1'b1;
          enter_d = '0;
        end else begin
          enter_d = enter_sum[tdh_pkg::CntW] ? tdh_pkg::CntMax : enter_sum[tdh_pkg::CntW-1:0];
        end
      end else begin
        enter_d = '0;
      end
    end else begin
      if (bright) begin
        if (leave_q >= cfg_i.leave_time) begin
          dark_d  = 1'b0;
          leave_d = '0;
        end else begin
          leave_d = leave_sum[tdh_pkg::CntW] ? tdh_pkg::CntMax : leave_sum[tdh_pkg::CntW-1:0];
        end
      end else begin
        leave_d = '0;
      end
    end
  end

  // State doubles as the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dark_q      <= 1'b0;
      enter_q     <= '0;
      leave_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        dark_q  <= dark_d;
        enter_q <= enter_d;
        leave_q <= leave_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dark_o  = dark_q;
  assign out_enter_o = enter_q;
  assign out_leave_o = leave_q;

endmodule

/* hw/rtl/tdh_checker.sv */
// Port-level assertions for the twilight dark hysteresis block, with its bind.
module tdh_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tdh_pkg::OutDataW-1:0]  m_axis_tdata
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Entering dark always clears the entry counter, and dark never touches it.
  a_dark_enter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'd0)
    else $error("entry counter nonzero while dark");

  // Leaving dark always clears the leave counter, and day mode never touches it.
  a_day_leave_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:17] == 16'd0)
    else $error("leave counter nonzero while not dark");

  // With the result side draining, the input side never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with result side ready");

endmodule

bind twilight_dark_hysteresis tdh_checker u_tdh_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the twilight dark hysteresis block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned IdxW = tdh_pkg::IdxW;
  localparam int unsigned LvlW = tdh_pkg::LvlW;
  localparam int unsigned CntW = tdh_pkg::CntW;
  localparam logic KindTick = tdh_pkg::KindTick;
  localparam logic KindInit = tdh_pkg::KindInit;

  // Index that lies past the last register; writes to it must be ignored.
  localparam logic [IdxW-1:0] RegNone = 3'd7;
  localparam logic [LvlW-1:0] IrNightReset = 16'd255;
  localparam int unsigned StrongStep = 3;
  localparam int unsigned WeakStep = 2;
  localparam int unsigned LeaveStep = 1;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic            kind;
    logic            twilight;
    logic [LvlW-1:0] ambient;
    logic [LvlW-1:0] forward;
    logic [LvlW-1:0] infrared;
  } sample_t;

  typedef struct packed {
    logic            dark;
    logic [CntW-1:0] enter_cnt;
    logic [CntW-1:0] leave_cnt;
  } light_state_t;

  typedef struct packed {
    sample_t      s;
    bit           typed;
    light_state_t want;
  } opening_row_t;

  typedef enum int {MOOD_STRONG, MOOD_WEAK, MOOD_BRIGHT, MOOD_NOISE} mood_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // [0] twilight_on, [16:1] ambient_level, [32:17] forward_level,
  // [48:33] infrared_level, [55:49] zero
  logic [tdh_pkg::InDataW-1:0]  s_axis_tdata;
  // [0] kind
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // [0] dark_active, [16:1] enter_count, [32:17] leave_count, [39:33] zero
  logic [tdh_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         cfg_we_i;
  logic [IdxW-1:0]              cfg_idx_i;
  logic [LvlW-1:0]              cfg_wdata_i;

  // Shadow of the thresholds and of the mode and counters.
  logic [LvlW-1:0] reg_shadow [7];
  logic            dark_now;
  logic [CntW-1:0] enter_now;
  logic [CntW-1:0] leave_now;

  light_state_t mode_q [$];
  int unsigned  mismatch_count = 0;
  bit           idle_on = 1'b1;
  mood_e        mood = MOOD_NOISE;
  int unsigned  run_left = 0;

  // Hand-picked beats: edges of every rule, both kinds, both branches.
  opening_row_t opening_rows [24] = '{
    '{'{KindTick, 1'b0, 16'd0,     16'd0,     16'd0},     1'b1, '{1'b0, 16'd3, 16'd0}},
    '{'{KindTick, 1'b1, 16'hffff,  16'hffff,  16'hffff},  1'b1, '{1'b0, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'd999,   16'd999,   16'hffff},  1'b1, '{1'b0, 16'd3, 16'd0}},
    '{'{KindTick, 1'b0, 16'd332,   16'd1499,  16'd332},   1'b1, '{1'b0, 16'd5, 16'd0}},
    '{'{KindTick, 1'b0, 16'd333,   16'd1499,  16'd0},     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'd0,     16'd1500,  16'd0},     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'd0,     16'd999,   16'd0},     1'b1, '{1'b0, 16'd3, 16'd0}},
    '{'{KindTick, 1'b0, 16'd0,     16'd0,     16'd333},   1'b1, '{1'b0, 16'd6, 16'd0}},
    '{'{KindInit, 1'b1, 16'd999,   16'd999,   16'd0},     1'b1, '{1'b1, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'd1501,  16'd1501,  16'd86},    1'b1, '{1'b1, 16'd0, 16'd1}},
    '{'{KindTick, 1'b0, 16'd1500,  16'hffff,  16'hffff},  1'b1, '{1'b1, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'hffff,  16'hffff,  16'hffff},  1'b1, '{1'b1, 16'd0, 16'd1}},
    '{'{KindTick, 1'b0, 16'hffff,  16'd1500,  16'hffff},  1'b1, '{1'b1, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'hffff,  16'hffff,  16'hffff},  1'b1, '{1'b1, 16'd0, 16'd1}},
    '{'{KindTick, 1'b0, 16'hffff,  16'hffff,  16'd85},    1'b1, '{1'b1, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'hffff,  16'hffff,  16'hffff},  1'b1, '{1'b1, 16'd0, 16'd1}},
    '{'{KindTick, 1'b0, 16'd1501,  16'd1501,  16'd86},    1'b1, '{1'b1, 16'd0, 16'd2}},
    '{'{KindInit, 1'b1, 16'd0,     16'd0,     16'd0},     1'b1, '{1'b1, 16'd0, 16'd2}},
    '{'{KindTick, 1'b0, 16'd0,     16'd0,     16'd0},     1'b1, '{1'b1, 16'd0, 16'd0}},
    '{'{KindInit, 1'b0, 16'd0,     16'd0,     16'd0},     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{'{KindTick, 1'b0, 16'd0,     16'd0,     16'd0},     1'b1, '{1'b0, 16'd3, 16'd0}},
    '{'{KindInit, 1'b1, 16'd1000,  16'd0,     16'd0},     1'b1, '{1'b0, 16'd3, 16'd0}},
    '{'{KindTick, 1'b1, 16'h5a5a,  16'ha5a5,  16'h3c3c},  1'b0, '0},
    '{'{KindInit, 1'b1, 16'd1,     16'd2,     16'hfffe},  1'b0, '0}
  };

  twilight_dark_hysteresis i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Switch mode; entering a mode clears that mode's own counter.
  function automatic void switch_mode(bit go_dark);
    dark_now = go_dark;
    if (go_dark) begin
      enter_now = '0;
    end else begin
      leave_now = '0;
    end
  endfunction

  // Advance the mode and counters by one accepted beat and return them.
  function automatic light_state_t advance_lights(sample_t s);
    int unsigned amb_lim, fwd_lim, amb_third, fwd_wide, sum;
    bit strong_hit, weak_hit, bright;
    amb_lim   = 32'(reg_shadow[tdh_pkg::REG_ENTER_AMB]);
    fwd_lim   = 32'(reg_shadow[tdh_pkg::REG_ENTER_FWD]);
    amb_third = amb_lim / 3;
    fwd_wide  = fwd_lim + fwd_lim / 2;
    strong_hit = (s.ambient < amb_lim) && (s.forward < fwd_lim);
    weak_hit   = (s.ambient < amb_third) && (s.forward < fwd_wide) &&
                 (s.infrared < amb_third);
    bright = (s.forward > reg_shadow[tdh_pkg::REG_LEAVE_FWD]) &&
             (s.ambient > reg_shadow[tdh_pkg::REG_LEAVE_AMB]) &&
             (32'(s.infrared) > reg_shadow[tdh_pkg::REG_IR_NIGHT] / 3);
    if (s.kind == KindInit) begin
      switch_mode(s.twilight && strong_hit);
    end else if (!dark_now) begin
      if (strong_hit || weak_hit) begin
        if (enter_now >= reg_shadow[tdh_pkg::REG_ENTER_TIME]) begin
          switch_mode(1'b1);
        end else begin
          sum = enter_now + (strong_hit ? StrongStep : WeakStep);
          enter_now = (sum > tdh_pkg::CntMax) ? tdh_pkg::CntMax : CntW'(sum);
        end
      end else begin
        enter_now = '0;
      end
    end else begin
      if (bright) begin
        if (leave_now >= reg_shadow[tdh_pkg::REG_LEAVE_TIME]) begin
          switch_mode(1'b0);
        end else begin
          sum = leave_now + LeaveStep;
          leave_now = (sum > tdh_pkg::CntMax) ? tdh_pkg::CntMax : CntW'(sum);
        end
      end else begin
        leave_now = '0;
      end
    end
    return '{dark_now, enter_now, leave_now};
  endfunction

  // Levels under a limit, now and then exactly on it.
  function automatic logic [LvlW-1:0] pick_below(int unsigned lim);
    int unsigned top;
    top = (lim > 65536) ? 65536 : lim;
    if (top == 0 || $urandom_range(0, 7) == 0) begin
      return LvlW'((top > 65535) ? 65535 : top);
    end
    return LvlW'($urandom_range(0, top - 1));
  endfunction

  // Levels over a limit, now and then exactly on it.
  function automatic logic [LvlW-1:0] pick_above(int unsigned lim);
    if (lim >= 65535 || $urandom_range(0, 7) == 0) begin
      return LvlW'((lim > 65535) ? 65535 : lim);
    end
    return LvlW'($urandom_range(lim + 1, 65535));
  endfunction

  function automatic logic [LvlW-1:0] pick_any();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return LvlW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random beats come in runs that share one lighting condition.
  function automatic sample_t next_sample();
    sample_t s;
    int unsigned amb_lim, fwd_lim;
    amb_lim = 32'(reg_shadow[tdh_pkg::REG_ENTER_AMB]);
    fwd_lim = 32'(reg_shadow[tdh_pkg::REG_ENTER_FWD]);
    if (run_left == 0) begin
      mood = mood_e'($urandom_range(0, 3));
      run_left = $urandom_range(1, 12);
    end
    run_left--;
    s.kind = ($urandom_range(0, 15) == 0) ? KindInit : KindTick;
    s.twilight = 1'($urandom_range(0, 1));
    case (mood)
      MOOD_STRONG: begin
        s.ambient = pick_below(amb_lim);
        s.forward = pick_below(fwd_lim);
        s.infrared = pick_any();
      end
      MOOD_WEAK: begin
        s.ambient = pick_below(amb_lim / 3);
        s.forward = pick_below(fwd_lim + fwd_lim / 2);
        s.infrared = pick_below(amb_lim / 3);
      end
      MOOD_BRIGHT: begin
        s.ambient = pick_above(32'(reg_shadow[tdh_pkg::REG_LEAVE_AMB]));
        s.forward = pick_above(32'(reg_shadow[tdh_pkg::REG_LEAVE_FWD]));
        s.infrared = pick_above(reg_shadow[tdh_pkg::REG_IR_NIGHT] / 3);
      end
      default: begin
        s.ambient = pick_any();
        s.forward = pick_any();
        s.infrared = pick_any();
      end
    endcase
    return s;
  endfunction

  // Offer one beat, at times with a random gap ahead of it, and log its expectation.
  task automatic send_sample(sample_t s, bit typed, light_state_t want);
    light_state_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.kind;
    s_axis_tdata  <= {7'd0, s.infrared, s.forward, s.ambient, s.twilight};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_lights(s);
    mode_q.push_back(typed ? want : predicted);
  endtask

  // Stop offering beats and wait for every result to come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mode_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [LvlW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx <= tdh_pkg::REG_IR_NIGHT) begin
      reg_shadow[idx] = val;
    end
  endtask

  task automatic program_limits(logic [LvlW-1:0] e_amb, logic [LvlW-1:0] e_fwd,
                                logic [CntW-1:0] e_time, logic [LvlW-1:0] l_amb,
                                logic [LvlW-1:0] l_fwd, logic [CntW-1:0] l_time,
                                logic [LvlW-1:0] ir_night);
    write_reg(tdh_pkg::REG_ENTER_AMB, e_amb);
    write_reg(tdh_pkg::REG_ENTER_FWD, e_fwd);
    write_reg(tdh_pkg::REG_ENTER_TIME, e_time);
    write_reg(tdh_pkg::REG_LEAVE_AMB, l_amb);
    write_reg(tdh_pkg::REG_LEAVE_FWD, l_fwd);
    write_reg(tdh_pkg::REG_LEAVE_TIME, l_time);
    write_reg(tdh_pkg::REG_IR_NIGHT, ir_night);
    write_reg(RegNone, LvlW'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_sample(next_sample(), 1'b0, '0);
    drain();
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Compare one result beat with the oldest expectation.
  task automatic check_result(logic [tdh_pkg::OutDataW-1:0] beat);
    light_state_t want;
    if (mode_q.size() == 0) begin
      note_mismatch("unexpected result beat", 0, 32'(beat));
    end else begin
      want = mode_q.pop_front();
      if (beat[0] !== want.dark) begin
        note_mismatch("dark_active", 32'(want.dark), 32'(beat[0]));
      end
      if (beat[16:1] !== want.enter_cnt) begin
        note_mismatch("enter_count", 32'(want.enter_cnt), 32'(beat[16:1]));
      end
      if (beat[32:17] !== want.leave_cnt) begin
        note_mismatch("leave_count", 32'(want.leave_cnt), 32'(beat[32:17]));
      end
    end
  endtask

  // Result side: check accepted beats and stall in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed rows, then random phases.
  initial begin
    reg_shadow[tdh_pkg::REG_ENTER_AMB]  = tdh_pkg::RstEnterAmb;
    reg_shadow[tdh_pkg::REG_ENTER_FWD]  = tdh_pkg::RstEnterFwd;
    reg_shadow[tdh_pkg::REG_ENTER_TIME] = tdh_pkg::RstEnterTime;
    reg_shadow[tdh_pkg::REG_LEAVE_AMB]  = tdh_pkg::RstLeaveAmb;
    reg_shadow[tdh_pkg::REG_LEAVE_FWD]  = tdh_pkg::RstLeaveFwd;
    reg_shadow[tdh_pkg::REG_LEAVE_TIME] = tdh_pkg::RstLeaveTime;
    reg_shadow[tdh_pkg::REG_IR_NIGHT]   = IrNightReset;
    dark_now  = 1'b0;
    enter_now = '0;
    leave_now = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KindTick;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= tdh_pkg::REG_ENTER_AMB;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      send_sample(opening_rows[i].s, opening_rows[i].typed, opening_rows[i].want);
    end
    drain();

    // Extreme settings: zero times with full-scale limits, and the reverse.
    program_limits('1, '1, '0, '1, '1, '0, '1);
    run_random(60);
    program_limits('0, '0, '1, '0, '0, '1, '0);
    run_random(60);

    repeat (4) begin
      program_limits(LvlW'($urandom_range(30, 4000)), LvlW'($urandom_range(30, 4000)),
                     CntW'($urandom_range(0, 8)), LvlW'($urandom_range(30, 6000)),
                     LvlW'($urandom_range(30, 6000)), CntW'($urandom_range(0, 8)),
                     LvlW'($urandom_range(0, 65535)));
      run_random(60);
    end

    // Closing phase runs at full rate on both sides.
    idle_on = 1'b0;
    program_limits(tdh_pkg::RstEnterAmb, tdh_pkg::RstEnterFwd,
                   CntW'($urandom_range(0, 9)), tdh_pkg::RstLeaveAmb,
                   tdh_pkg::RstLeaveFwd, CntW'($urandom_range(0, 9)), IrNightReset);
    run_random(60);

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && mode_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* twilight_dark_hysteresis.f */
hw/rtl/tdh_pkg.sv
hw/rtl/tdh_cfg.sv
hw/rtl/tdh_core.sv
hw/rtl/twilight_dark_hysteresis.sv
hw/rtl/tdh_checker.sv
dv/tb.sv
